// ===== src/fftb_pkg.sv =====
package fftb_pkg;

  // Transform size and length of the twiddle sequence. The transform size is
  // taken to be a power of two of at least eight.
  localparam int unsigned FFT_SIZE      = 1024;
  localparam int unsigned TWIDDLE_COUNT = 512;

  localparam int unsigned LOG2N    = $clog2(FFT_SIZE);
  localparam int unsigned CNT_W    = (TWIDDLE_COUNT > 1) ? $clog2(TWIDDLE_COUNT) : 1;
  localparam int unsigned KEXT_W   = (CNT_W > LOG2N) ? CNT_W : LOG2N;
  localparam int unsigned TW_QTR   = FFT_SIZE / 4;
  localparam int unsigned TW_IDX_W = LOG2N - 2;

  // Datapath widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned SUM_W    = 27;
  localparam int unsigned SCALE_W  = 18;
  localparam int unsigned SCALED_W = SUM_W + SCALE_W;
  localparam int unsigned FRAC_W   = 23;

  // 1/sqrt(2) in Q1.17.
  localparam logic signed [SCALE_W-1:0] INV_SQRT2 = 18'sd92681;
  localparam logic signed [SAMPLE_W-1:0] CLIP_MAX = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] CLIP_MIN = -16'sd32767;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] im;
    logic signed [SAMPLE_W-1:0] re;
  } cplx16_t;

  typedef struct packed {
    logic    last;
    cplx16_t b;
    cplx16_t a;
  } in_item_t;

  typedef struct packed {
    logic    last;
    cplx16_t w;
    cplx16_t b;
    cplx16_t a;
  } tw_item_t;

  typedef struct packed {
    logic                    last;
    logic signed [SUM_W-1:0] di;
    logic signed [SUM_W-1:0] dr;
    logic signed [SUM_W-1:0] si;
    logic signed [SUM_W-1:0] sr;
  } sum_item_t;

  typedef struct packed {
    logic    last;
    cplx16_t diff;
    cplx16_t sum;
  } out_item_t;

  // One quarter-wave ROM entry: cosine and sine magnitudes in Q2.14.
  typedef struct packed {
    logic [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0] c;
  } tw_entry_t;

  typedef tw_entry_t [TW_QTR-1:0] tw_rom_t;

  localparam logic [63:0] LO32       = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1846;

  // Quotient and remainder of pi/2 in Q60 by the transform size.
  localparam logic [63:0] HALF_PI_DIV_N = HALF_PI_Q60 >> LOG2N;
  localparam logic [63:0] HALF_PI_MOD_N = HALF_PI_Q60 & 64'(FFT_SIZE - 1);

  // (a*b) >> 60 for operands below 2^62, built from 32-bit partial products.
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al  = a & LO32;
    ah  = a >> 32;
    bl  = b & LO32;
    bh  = b >> 32;
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + (lh & LO32) + (hl & LO32);
    lo  = (ll & LO32) | (mid << 32);
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 4) | (lo >> 60);
  endfunction

  // Unsigned quotient by shift and subtract; only used while the ROM is built.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo, rem;
    quo = '0;
    rem = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[62:0], num[j]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[j] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [SAMPLE_W-1:0] q60_to_q14(logic [63:0] v);
    logic [63:0] t;
    t = (v + (64'd1 << 45)) >> 46;
    if (v[63]) begin
      return '0;
    end
    return t[SAMPLE_W-1:0];
  endfunction

  // First-quadrant cosine and sine for angle r*pi/(2*FFT_SIZE), r below FFT_SIZE,
  // evaluated at elaboration by a Taylor series in Q60.
  function automatic tw_entry_t twiddle_entry(logic [63:0] r);
    logic [63:0] theta, x2, cs, ct, sn, st, dc, ds;
    tw_entry_t   e;
    theta = HALF_PI_DIV_N * r + ((HALF_PI_MOD_N * r) >> LOG2N);
    x2    = mul_q60(theta, theta);
    cs    = ONE_Q60;
    ct    = ONE_Q60;
    sn    = theta;
    st    = theta;
    for (int i = 1; i <= 24; i++) begin
      dc = 64'((2 * i - 1) * (2 * i));
      ds = 64'((2 * i) * (2 * i + 1));
      ct = udiv64(mul_q60(ct, x2), dc);
      st = udiv64(mul_q60(st, x2), ds);
      if ((i & 1) == 1) begin
        cs = cs - ct;
        sn = sn - st;
      end else begin
        cs = cs + ct;
        sn = sn + st;
      end
    end
    e.c = q60_to_q14(cs);
    e.s = q60_to_q14(sn);
    return e;
  endfunction

  function automatic tw_rom_t build_tw_rom();
    tw_rom_t rom;
    for (int i = 0; i < TW_QTR; i++) begin
      rom[i] = twiddle_entry(64'(4 * i));
    end
    return rom;
  endfunction

endpackage

// ===== src/fft_radix2_butterfly_stage.sv =====
// Radix-2 decimation-in-time butterfly for a streaming fixed-point FFT. Each
// transfer on the slave side carries one pair of complex samples a and b; the
// block multiplies b by the twiddle factor W(k) = cos(2*pi*k/N) - j*sin(2*pi*k/N)
// (Q2.14, N = 1024, held as a quarter-wave ROM of 256 entries), floor-shifts the
// product by eight bits, forms a+bW and a-bW, scales both by 1/sqrt(2), rounds
// half to even and clips symmetrically to +-32767. The twiddle index k starts at
// zero after reset, steps by one for every accepted pair and returns to zero
// after a pair flagged with tlast or after the 512th pair. Throughput is one
// pair per clock while the master side does not stall. There are six register
// stages (input, ROM lookup, complex multiply, add/subtract, scaling multiply,
// round and clip); the master side is driven from the round and clip register.
// Every stage has its own valid bit and a stage moves whenever the stage after
// it is empty or moving, so back-pressure on the master side stalls the pipe
// without losing or repeating any transfer, and bubbles are squeezed out.
module fft_radix2_butterfly_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // a_real[15:0], a_imag[31:16], b_real[47:32], b_imag[63:48]
  input  logic        s_axis_tlast,  // last pair of a frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // sum_real[15:0], sum_imag[31:16],
                                     // diff_real[47:32], diff_imag[63:48]
  output logic        m_axis_tlast   // copy of the input last flag
);
  import fftb_pkg::*;

  in_item_t  in_item;
  tw_item_t  tw_item;
  sum_item_t sum_item;
  out_item_t out_item;
  logic      tw_valid, tw_ready;
  logic      sum_valid, sum_ready;

  // Unpack the input transfer; the first field sits in the lowest bits.
  assign in_item.a.re = s_axis_tdata[15:0];
  assign in_item.a.im = s_axis_tdata[31:16];
  assign in_item.b.re = s_axis_tdata[47:32];
  assign in_item.b.im = s_axis_tdata[63:48];
  assign in_item.last = s_axis_tlast;

  // Twiddle counter, input register and ROM lookup.
  fftb_twiddle u_twiddle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (tw_valid),
    .out_ready_i (tw_ready),
    .out_item_o  (tw_item)
  );

  // Complex multiply b*W and the butterfly add and subtract.
  fftb_cmul u_cmul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tw_valid),
    .in_ready_o  (tw_ready),
    .in_item_i   (tw_item),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .out_item_o  (sum_item)
  );

  // Scaling by 1/sqrt(2), rounding and clipping; its last stage is the output register.
  fftb_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .in_item_i   (sum_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = {out_item.diff.im, out_item.diff.re, out_item.sum.im, out_item.sum.re};
  assign m_axis_tlast = out_item.last;

endmodule

// ===== src/fftb_twiddle.sv =====
module fftb_twiddle (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fftb_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fftb_pkg::tw_item_t out_item_o
);
  import fftb_pkg::*;

  localparam tw_rom_t TwRom = build_tw_rom();

  logic                  va_q, vb_q;
  logic                  rdy_a, rdy_b;
  in_item_t              ia_q;
  logic [CNT_W-1:0]      k_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  tw_item_t              ob_q, ob_d;
  logic [KEXT_W-1:0]     kext;
  logic [1:0]            quad;
  logic [TW_IDX_W-1:0]   ridx;
  tw_entry_t             ent;
  logic [SAMPLE_W-1:0]   neg_c, neg_s;

  assign rdy_b      = !vb_q || out_ready_i;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  // The counter restarts after the last pair of a frame or at the end of the table.
  always_comb begin
    if (in_item_i.last || (cnt_q == CNT_W'(TWIDDLE_COUNT - 1))) begin
      cnt_d = '0;
    end else begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      cnt_q <= '0;
    end else if (rdy_a) begin
      va_q <= in_valid_i;
      if (in_valid_i) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      ia_q <= in_item_i;
      k_q  <= cnt_q;
    end
  end

  // Quarter-wave lookup: the top two bits of the angle index pick the quadrant.
  assign kext  = KEXT_W'(k_q);
  assign quad  = kext[LOG2N-1:LOG2N-2];
  assign ridx  = kext[TW_IDX_W-1:0];
  assign ent   = TwRom[ridx];
  assign neg_c = SAMPLE_W'(-ent.c);
  assign neg_s = SAMPLE_W'(-ent.s);

  always_comb begin
    ob_d.a    = ia_q.a;
    ob_d.b    = ia_q.b;
    ob_d.last = ia_q.last;
    case (quad)
      2'd0: begin
        ob_d.w.re = ent.c;
        ob_d.w.im = neg_s;
      end
      2'd1: begin
        ob_d.w.re = neg_s;
        ob_d.w.im = neg_c;
      end
      2'd2: begin
        ob_d.w.re = neg_c;
        ob_d.w.im = ent.s;
      end
      default: begin
        ob_d.w.re = ent.s;
        ob_d.w.im = ent.c;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      ob_q <= ob_d;
    end
  end

  assign out_valid_o = vb_q;
  assign out_item_o  = ob_q;

endmodule

// ===== src/fftb_cmul.sv =====
module fftb_cmul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fftb_pkg::tw_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fftb_pkg::sum_item_t out_item_o
);
  import fftb_pkg::*;

  logic                     vp_q, vs_q;
  logic                     rdy_p, rdy_s;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  cplx16_t                  a_q;
  logic                     last_q;
  logic signed [PROD_W:0]   pr, pi;
  logic signed [SUM_W-1:0]  a6r, a6i, b6r, b6i;
  sum_item_t                os_q, os_d;

  assign rdy_s      = !vs_q || out_ready_i;
  assign rdy_p      = !vp_q || rdy_s;
  assign in_ready_o = rdy_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (rdy_p) begin
      vp_q <= in_valid_i;
    end
  end

  // Four partial products of b times W.
  always_ff @(posedge clk_i) begin
    if (rdy_p && in_valid_i) begin
      p_rr_q <= in_item_i.b.re * in_item_i.w.re;
      p_ii_q <= in_item_i.b.im * in_item_i.w.im;
      p_ri_q <= in_item_i.b.re * in_item_i.w.im;
      p_ir_q <= in_item_i.b.im * in_item_i.w.re;
      a_q    <= in_item_i.a;
      last_q <= in_item_i.last;
    end
  end

  // bW is floor-shifted by eight bits; a is brought to the same Q-scale.
  always_comb begin
    pr  = $signed({p_rr_q[PROD_W-1], p_rr_q}) - $signed({p_ii_q[PROD_W-1], p_ii_q});
    pi  = $signed({p_ri_q[PROD_W-1], p_ri_q}) + $signed({p_ir_q[PROD_W-1], p_ir_q});
    b6r = SUM_W'($signed(pr[PROD_W:8]));
    b6i = SUM_W'($signed(pi[PROD_W:8]));
    a6r = SUM_W'($signed({a_q.re, 6'b0}));
    a6i = SUM_W'($signed({a_q.im, 6'b0}));
    os_d.sr   = a6r + b6r;
    os_d.si   = a6i + b6i;
    os_d.dr   = a6r - b6r;
    os_d.di   = a6i - b6i;
    os_d.last = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (rdy_s) begin
      vs_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_s && vp_q) begin
      os_q <= os_d;
    end
  end

  assign out_valid_o = vs_q;
  assign out_item_o  = os_q;

endmodule

// ===== src/fftb_scale.sv =====
module fftb_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fftb_pkg::sum_item_t in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fftb_pkg::out_item_t out_item_o
);
  import fftb_pkg::*;

  logic                       vm_q, vo_q;
  logic                       rdy_m, rdy_o;
  logic signed [SCALED_W-1:0] m_sr_q, m_si_q, m_dr_q, m_di_q;
  logic                       last_q;
  out_item_t                  oo_q, oo_d;

  // Round half to even at the binary point below bit 23, then clip to +-32767.
  function automatic logic signed [SAMPLE_W-1:0] round_clip(
    logic signed [SCALED_W-1:0] x
  );
    localparam int unsigned QW = SCALED_W - FRAC_W;
    logic signed [QW-1:0] q;
    logic signed [QW:0]   qr;
    logic                 inc;
    q   = x[SCALED_W-1:FRAC_W];
    inc = x[FRAC_W-1] && ((|x[FRAC_W-2:0]) || q[0]);
    qr  = $signed({q[QW-1], q}) + $signed({{QW{1'b0}}, inc});
    if (qr > $signed((QW + 1)'(CLIP_MAX))) begin
      return CLIP_MAX;
    end
    if (qr < $signed((QW + 1)'(CLIP_MIN))) begin
      return CLIP_MIN;
    end
    return qr[SAMPLE_W-1:0];
  endfunction

  assign rdy_o      = !vo_q || out_ready_i;
  assign rdy_m      = !vm_q || rdy_o;
  assign in_ready_o = rdy_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (rdy_m) begin
      vm_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_m && in_valid_i) begin
      m_sr_q <= in_item_i.sr * INV_SQRT2;
      m_si_q <= in_item_i.si * INV_SQRT2;
      m_dr_q <= in_item_i.dr * INV_SQRT2;
      m_di_q <= in_item_i.di * INV_SQRT2;
      last_q <= in_item_i.last;
    end
  end

  always_comb begin
    oo_d.sum.re  = round_clip(m_sr_q);
    oo_d.sum.im  = round_clip(m_si_q);
    oo_d.diff.re = round_clip(m_dr_q);
    oo_d.diff.im = round_clip(m_di_q);
    oo_d.last    = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdy_o) begin
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vm_q) begin
      oo_q <= oo_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_item_o  = oo_q;

endmodule
